/* hw/rtl/hcbd_pkg.sv */
// Shared constants, types and helpers for the chunked body decoder.
package hcbd_pkg;

  // Default width of lengths and counts
  localparam int LengthBitsDefault = 24;
  // body_length value after reset, before it is cut to the length width
  localparam int BodyLengthReset = 65535;

  // Decoder phase codes
  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_SEP    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // End status codes
  localparam logic [1:0] ST_ZERO_CHUNK = 2'd0;
  localparam logic [1:0] ST_INPUT_END  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE  = 2'd2;

  // Framing characters
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Result of one step, apart from the decoded length
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] status;
  } res_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* hw/rtl/hcbd_step.sv */
// Per-byte chunk framing state machine: state registers and next-state logic.
module hcbd_step #(
  parameter int LENGTH_BITS = hcbd_pkg::LengthBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  logic [LENGTH_BITS-1:0] body_length,
  output hcbd_pkg::res_t         res,
  output logic [LENGTH_BITS-1:0] decoded_length
);

  localparam int AccBits = LENGTH_BITS + 1;

  logic [2:0]             phase, phase_next;
  logic [AccBits-1:0]     acc, acc_next;
  logic                   zero_seen, zero_seen_next;
  logic [LENGTH_BITS-1:0] left, left_next;
  logic [LENGTH_BITS-1:0] emitted, emitted_next;
  logic [1:0]             end_status, end_status_next;

  hcbd_pkg::hex_t         hx;
  logic                   is_crlf;
  logic                   is_x;
  logic                   do_close;
  logic                   do_first;
  logic                   do_pass;
  logic [LENGTH_BITS-1:0] pass_left;
  logic [AccBits-1:0]     acc_sat;
  logic [AccBits-1:0]     first_sum;
  logic                   have_byte;

  assign hx      = hcbd_pkg::hex_decode(in_byte);
  assign is_crlf = (in_byte == hcbd_pkg::CH_CR) || (in_byte == hcbd_pkg::CH_LF);
  assign is_x    = (in_byte == hcbd_pkg::CH_X_LOWER) || (in_byte == hcbd_pkg::CH_X_UPPER);

  // Shift in a digit, saturating at all ones
  assign acc_sat = (acc[AccBits-1 -: 4] != 4'd0) ? {AccBits{1'b1}}
                                                 : {acc[AccBits-5:0], hx.val};

  // Work out the next state for the byte in the input register
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    zero_seen_next  = zero_seen;
    left_next       = left;
    emitted_next    = emitted;
    end_status_next = end_status;
    do_close        = 1'b0;
    do_first        = 1'b0;
    do_pass         = 1'b0;
    pass_left       = left;
    have_byte       = 1'b0;
    first_sum       = '0;

    case (phase)
      hcbd_pkg::PH_SKIP: begin
        if (hx.ok) begin
          acc_next       = AccBits'(hx.val);
          zero_seen_next = (hx.val == 4'd0);
          phase_next     = hcbd_pkg::PH_SIZE;
          do_close       = in_last;
        end
      end
      hcbd_pkg::PH_SIZE: begin
        if (hx.ok) begin
          acc_next       = acc_sat;
          zero_seen_next = 1'b0;
          do_close       = in_last;
        end else if (zero_seen && is_x) begin
          zero_seen_next = 1'b0;
          phase_next     = hcbd_pkg::PH_PREFIX;
          if (in_last) begin
            end_status_next = hcbd_pkg::ST_ZERO_CHUNK;
            phase_next      = hcbd_pkg::PH_DONE;
          end
        end else if (acc == '0) begin
          end_status_next = hcbd_pkg::ST_ZERO_CHUNK;
          phase_next      = hcbd_pkg::PH_DONE;
        end else if (acc > {1'b0, body_length}) begin
          end_status_next = hcbd_pkg::ST_TOO_LARGE;
          phase_next      = hcbd_pkg::PH_DONE;
        end else begin
          left_next = acc[LENGTH_BITS-1:0];
          pass_left = acc[LENGTH_BITS-1:0];
          if (is_crlf) begin
            phase_next = hcbd_pkg::PH_SEP;
          end else begin
            do_first = 1'b1;
          end
        end
      end
      hcbd_pkg::PH_PREFIX: begin
        if (hx.ok) begin
          acc_next   = AccBits'(hx.val);
          phase_next = hcbd_pkg::PH_SIZE;
          do_close   = in_last;
        end else begin
          end_status_next = hcbd_pkg::ST_ZERO_CHUNK;
          phase_next      = hcbd_pkg::PH_DONE;
        end
      end
      hcbd_pkg::PH_SEP: begin
        if (!is_crlf) begin
          do_first = 1'b1;
        end
      end
      hcbd_pkg::PH_DATA: begin
        do_pass = 1'b1;
      end
      default: begin
      end
    endcase

    // Close a size that the last byte cut off
    if (do_close) begin
      if (acc_next == '0) begin
        end_status_next = hcbd_pkg::ST_ZERO_CHUNK;
        phase_next      = hcbd_pkg::PH_DONE;
      end else if (acc_next > {1'b0, body_length}) begin
        end_status_next = hcbd_pkg::ST_TOO_LARGE;
        phase_next      = hcbd_pkg::PH_DONE;
      end
    end

    // Check the whole chunk fits before its first byte goes out
    if (do_first) begin
      first_sum = {1'b0, emitted} + {1'b0, pass_left};
      if (first_sum > {1'b0, body_length}) begin
        end_status_next = hcbd_pkg::ST_TOO_LARGE;
        phase_next      = hcbd_pkg::PH_DONE;
      end else begin
        do_pass = 1'b1;
      end
    end

    // Pass one payload byte
    if (do_pass) begin
      have_byte    = 1'b1;
      emitted_next = emitted + 1'b1;
      left_next    = pass_left - 1'b1;
      phase_next   = (left_next != '0) ? hcbd_pkg::PH_DATA : hcbd_pkg::PH_SKIP;
    end

    // Build the result
    res.valid          = have_byte || in_last;
    res.out_byte       = have_byte ? in_byte : 8'd0;
    res.byte_valid     = have_byte;
    res.end_of_message = in_last;
    res.status         = in_last ? end_status_next : hcbd_pkg::ST_ZERO_CHUNK;
    decoded_length     = emitted_next;

    // Return to the start after the end item
    if (in_last) begin
      phase_next      = hcbd_pkg::PH_SKIP;
      acc_next        = '0;
      zero_seen_next  = 1'b0;
      left_next       = '0;
      emitted_next    = '0;
      end_status_next = hcbd_pkg::ST_INPUT_END;
    end
  end

  // Advance the state once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hcbd_pkg::PH_SKIP;
      acc        <= '0;
      zero_seen  <= 1'b0;
      left       <= '0;
      emitted    <= '0;
      end_status <= hcbd_pkg::ST_INPUT_END;
    end else if (fire) begin
      phase      <= phase_next;
      acc        <= acc_next;
      zero_seen  <= zero_seen_next;
      left       <= left_next;
      emitted    <= emitted_next;
      end_status <= end_status_next;
    end
  end

  // A data phase always has bytes left to pass
  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DATA |-> left != '0)
    else $error("data phase with no bytes left");

  // The end item returns the decoder to its start state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> phase == hcbd_pkg::PH_SKIP && emitted == '0 &&
                        end_status == hcbd_pkg::ST_INPUT_END)
    else $error("state not cleared after end item");

  // Once done, only the last byte leaves the done phase
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    fire && !in_last && phase == hcbd_pkg::PH_DONE |=> phase == hcbd_pkg::PH_DONE)
    else $error("left done phase before last byte");

  // Each payload byte advances the decoded count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && res.byte_valid && !in_last |=> emitted == $past(emitted) + 1'b1)
    else $error("decoded count did not advance");

  // No byte is passed once decoding has ended
  a_no_byte_done: assert property (@(posedge clk) disable iff (rst)
    phase == hcbd_pkg::PH_DONE |-> !res.byte_valid)
    else $error("payload byte after decoding ended");

endmodule

/* hw/rtl/http_chunked_body_decoder.sv */
// Chunked transfer decoder top level: stream ports, input and result registers.
// Each accepted byte waits in the input register until the output side is free; its result is then registered.
// Throughput: one body byte per cycle while the output is not stalled; the per-byte state update
// in hcbd_step is the single logic stage between the input register and the result register.
// Reset (rst, synchronous): clears pipeline valids and decoder state and sets
// body_length to 65535; configuration writes are taken at any time.
module http_chunked_body_decoder #(
  parameter int LENGTH_BITS = hcbd_pkg::LengthBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
  input  logic                   s_axis_tlast,   // last
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [((LENGTH_BITS + 10 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // m_axis_tdata from bit 0: out_byte (8), status (2), decoded_length (LENGTH_BITS), zero pad
  output logic                   m_axis_tuser,   // byte_valid
  output logic                   m_axis_tlast    // end_of_message
);

  localparam int OutBits = ((LENGTH_BITS + 10 + 7) / 8) * 8;
  localparam logic [LENGTH_BITS-1:0] BodyReset = LENGTH_BITS'(hcbd_pkg::BodyLengthReset);

  logic                   body_valid_unused;
  logic [LENGTH_BITS-1:0] body_length;
  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic                   out_free;
  logic                   fire;
  hcbd_pkg::res_t         res;
  logic [LENGTH_BITS-1:0] decoded_length;
  logic [7:0]             out_byte;
  logic [1:0]             out_status;
  logic [LENGTH_BITS-1:0] out_length;

  assign body_valid_unused = 1'b0;

  // Hold the configured body length
  always_ff @(posedge clk) begin
    if (rst) begin
      body_length <= BodyReset;
    end else if (cfg_we) begin
      body_length <= cfg_wdata;
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Capture each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= body_valid_unused;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  hcbd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .body_length    (body_length),
    .res            (res),
    .decoded_length (decoded_length)
  );

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_byte     <= res.out_byte;
      out_status   <= res.status;
      out_length   <= decoded_length;
      m_axis_tuser <= res.byte_valid;
      m_axis_tlast <= res.end_of_message;
    end
  end

  assign m_axis_tdata = OutBits'({out_length, out_status, out_byte});

endmodule

/* verif/hcbd_checker.sv */
// Scoreboard for the chunked body decoder: predicts each result and compares it.
module hcbd_checker
  import hcbd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault,
  parameter int TDATA_W = ((LENGTH_BITS + 10 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_W-1:0]     m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     fail_count,
  output int                     pending
);

  localparam int AccW = LENGTH_BITS + 1;

  // One decoded result: payload byte, flags, end status and running count
  typedef struct packed {
    logic [7:0]             data;
    logic                   has_byte;
    logic                   eom;
    logic [1:0]             code;
    logic [LENGTH_BITS-1:0] count;
  } decoded_t;

  decoded_t expected_q[$];

  // Decoder state as seen by the predictor
  logic [2:0]             phase;
  logic [LENGTH_BITS:0]   size_acc;
  logic                   zero_lead;
  logic [LENGTH_BITS-1:0] chunk_left;
  logic [LENGTH_BITS-1:0] emitted;
  logic [1:0]             end_code;
  logic [LENGTH_BITS-1:0] body_len;

  function automatic void clear_decoder();
    phase      = PH_SKIP;
    size_acc   = '0;
    zero_lead  = 1'b0;
    chunk_left = '0;
    emitted    = '0;
    end_code   = ST_INPUT_END;
  endfunction

  function automatic void end_decode(input logic [1:0] code);
    end_code = code;
    phase    = PH_DONE;
  endfunction

  // Size is complete because the body ends on it
  function automatic void close_size();
    if (size_acc == 0) begin
      end_decode(ST_ZERO_CHUNK);
    end else if (size_acc > body_len) begin
      end_decode(ST_TOO_LARGE);
    end
  endfunction

  function automatic logic pass_payload();
    emitted    = emitted + 1'b1;
    chunk_left = chunk_left - 1'b1;
    phase      = (chunk_left != 0) ? PH_DATA : PH_SKIP;
    return 1'b1;
  endfunction

  // Reject a chunk that would overrun the body, else pass its first byte
  function automatic logic open_chunk();
    if ({1'b0, emitted} + {1'b0, chunk_left} > {1'b0, body_len}) begin
      end_decode(ST_TOO_LARGE);
      return 1'b0;
    end
    return pass_payload();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    decoded_t         want;
    decoded_t         got;
    decoded_t         next;
    logic [7:0]       b;
    logic             fin;
    logic             took;
    int               d;
    longint unsigned  sum;

    if (rst) begin
      clear_decoder();
      body_len = LENGTH_BITS'(BodyLengthReset);
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        body_len = cfg_wdata;
      end

      // Compare each result transaction with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.data     = m_axis_tdata[7:0];
        got.code     = m_axis_tdata[9:8];
        got.count    = m_axis_tdata[10 +: LENGTH_BITS];
        got.has_byte = m_axis_tuser;
        got.eom      = m_axis_tlast;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none actual %0h", $time, got);
        end else begin
          want = expected_q.pop_front();
          check_field("out_byte", 32'(want.data), 32'(got.data));
          check_field("byte_valid", 32'(want.has_byte), 32'(got.has_byte));
          check_field("end_of_message", 32'(want.eom), 32'(got.eom));
          check_field("status", 32'(want.code), 32'(got.code));
          check_field("decoded_length", 32'(want.count), 32'(got.count));
        end
      end

      // Advance the predictor on each input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        b    = s_axis_tdata;
        fin  = s_axis_tlast;
        took = 1'b0;
        if (b >= "0" && b <= "9") begin
          d = int'(b) - int'("0");
        end else if (b >= "a" && b <= "f") begin
          d = int'(b) - int'("a") + 10;
        end else if (b >= "A" && b <= "F") begin
          d = int'(b) - int'("A") + 10;
        end else begin
          d = -1;
        end

        case (phase)
          PH_SKIP: begin
            if (d >= 0) begin
              size_acc  = AccW'(d);
              zero_lead = (d == 0);
              phase     = PH_SIZE;
              if (fin) close_size();
            end
          end
          PH_SIZE: begin
            if (d >= 0) begin
              // Grow the size and saturate at all ones
              sum = 64'(size_acc) * 64'd16 + 64'(d);
              size_acc  = ((sum >> (LENGTH_BITS + 1)) != 0) ? '1 : sum[LENGTH_BITS:0];
              zero_lead = 1'b0;
              if (fin) close_size();
            end else if (zero_lead && (b == CH_X_LOWER || b == CH_X_UPPER)) begin
              zero_lead = 1'b0;
              phase     = PH_PREFIX;
              if (fin) end_decode(ST_ZERO_CHUNK);
            end else if (size_acc == 0) begin
              end_decode(ST_ZERO_CHUNK);
            end else if (size_acc > body_len) begin
              end_decode(ST_TOO_LARGE);
            end else begin
              chunk_left = size_acc[LENGTH_BITS-1:0];
              if (b == CH_CR || b == CH_LF) begin
                phase = PH_SEP;
              end else begin
                took = open_chunk();
              end
            end
          end
          PH_PREFIX: begin
            if (d >= 0) begin
              size_acc = AccW'(d);
              phase    = PH_SIZE;
              if (fin) close_size();
            end else begin
              end_decode(ST_ZERO_CHUNK);
            end
          end
          PH_SEP: begin
            if (b != CH_CR && b != CH_LF) took = open_chunk();
          end
          PH_DATA: begin
            took = pass_payload();
          end
          default: ;
        endcase

        // Queue a result for a payload byte or the end of the body
        if (took || fin) begin
          next.data     = took ? b : 8'h00;
          next.has_byte = took;
          next.eom      = fin;
          next.code     = fin ? end_code : ST_ZERO_CHUNK;
          next.count    = emitted;
          expected_q.push_back(next);
          if (fin) clear_decoder();
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* verif/http_chunked_body_decoder_tb.sv */
// Testbench top for the chunked body decoder: clock, reset, stimulus and verdict.
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int LB          = LengthBitsDefault;
  localparam int TDW         = ((LB + 10 + 7) / 8) * 8;
  localparam int IdlePct     = 11;
  localparam int RandomItems = 1600;
  localparam int StallLimit  = 4000;

  typedef enum int {BODY_CLEAN, BODY_CUT, BODY_NOISE} body_kind_t;

  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic [LB-1:0]  cfg_wdata;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata;
  logic           s_axis_tlast;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [TDW-1:0] m_axis_tdata;
  logic           m_axis_tuser;
  logic           m_axis_tlast;
  int             fail_count;
  int             pending;
  logic           calm;
  int             sent;
  int             quiet_cycles;
  logic [7:0]     frame[$];

  http_chunked_body_decoder #(.LENGTH_BITS(LB)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hcbd_checker #(.LENGTH_BITS(LB)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except in the calm stretch
  always @(negedge clk) begin
    m_axis_tready = calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic void load_text(input string s);
    foreach (s[i]) frame.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  // Append a hex chunk size, sometimes with a prefix or a leading zero
  function automatic void put_size(input int unsigned value);
    bit started;
    started = 1'b0;
    case ($urandom_range(0, 9))
      0: load_text("0x");
      1: load_text("0X");
      2: load_text("0");
      default: ;
    endcase
    for (int k = 7; k >= 0; k--) begin
      if (started || ((value >> (4 * k)) & 15) != 0 || k == 0) begin
        started = 1'b1;
        frame.push_back(hex_char((value >> (4 * k)) & 15));
      end
    end
  endfunction

  // Send the frame byte by byte, marking its final byte as last
  task automatic send_frame();
    foreach (frame[i]) begin
      while (!calm && $urandom_range(0, 99) < IdlePct) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = frame[i];
      s_axis_tlast  = (i == frame.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
      @(negedge clk);
      sent++;
    end
    s_axis_tvalid = 1'b0;
  endtask

  initial begin
    body_kind_t  kind;
    int          body_count;
    int          cfg_step;
    int          payload_bytes;
    int          keep;
    int unsigned size_value;
    logic [7:0]  b;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    sent          = 0;
    body_count    = 0;
    cfg_step      = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: skip byte, CR/LF separator, byte extremes, prefix without hex
    frame.delete();
    load_text("g1\n");
    frame.push_back(8'hFF);
    load_text("0xq");
    frame.push_back(8'h00);
    send_frame();
    // X after a nonzero size is data; body ends on a digit after a prefix
    frame.delete();
    load_text("2X");
    frame.push_back(8'h80);
    load_text("0xA");
    send_frame();
    // Saturating size ending on the last byte
    frame.delete();
    load_text("FfFfFfF");
    send_frame();
    // Body ends on a lone zero digit, then on an upper-case prefix
    frame.delete();
    load_text("0");
    send_frame();
    frame.delete();
    load_text("0X");
    send_frame();

    while (sent < RandomItems) begin
      // Change body_length between bodies, once the decoder has drained
      if (body_count % 10 == 9) begin
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        case (cfg_step % 5)
          0: cfg_wdata = LB'(1);
          1: cfg_wdata = '1;
          2: cfg_wdata = LB'($urandom_range(20, 120));
          3: cfg_wdata = LB'($urandom_range(1, 24'hFFFFFF));
          default: cfg_wdata = LB'(BodyLengthReset);
        endcase
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_step++;
      end

      calm = (sent >= 700 && sent < 1000);
      keep = int'($urandom_range(0, 99));
      kind = (keep < 70) ? BODY_CLEAN : (keep < 85) ? BODY_CUT : BODY_NOISE;
      frame.delete();

      if (kind == BODY_NOISE) begin
        // Loose bytes rich in hex digits, prefix letters and line ends
        repeat ($urandom_range(1, 24)) begin
          b = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 7))
            0, 1, 2: b = hex_char($urandom_range(0, 15));
            3: b = $urandom_range(0, 1) ? CH_X_LOWER : CH_X_UPPER;
            4: b = $urandom_range(0, 1) ? CH_CR : CH_LF;
            default: ;
          endcase
          frame.push_back(b);
        end
      end else begin
        // Chunks with random payload, mostly well-formed, then the zero chunk
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 9) == 0) load_text(" \t");
          case ($urandom_range(0, 19))
            0: begin
              payload_bytes = int'($urandom_range(40, 120));
              size_value    = payload_bytes;
            end
            1: begin
              payload_bytes = 3;
              size_value    = $urandom;
            end
            default: begin
              payload_bytes = int'($urandom_range(1, 12));
              size_value    = payload_bytes;
            end
          endcase
          put_size(size_value);
          case ($urandom_range(0, 9))
            8: load_text("\n");
            9: ;
            default: load_text("\r\n");
          endcase
          for (int k = 0; k < payload_bytes; k++) begin
            b = 8'($urandom_range(0, 255));
            if (k == 0 && (b == CH_CR || b == CH_LF)) b = 8'h2E;
            frame.push_back(b);
          end
          load_text("\r\n");
        end
        put_size(0);
        load_text("\r\n\r\n");
        // Truncate some bodies at a random point
        if (kind == BODY_CUT) begin
          keep = int'($urandom_range(1, frame.size()));
          while (frame.size() > keep) void'(frame.pop_back());
        end
      end

      send_frame();
      body_count++;
    end
    calm = 1'b0;

    // Drain outstanding results, then give the verdict
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
